// ===== hdl/s256sh_pkg.sv =====
`default_nettype none

package s256sh_pkg;

  // Input word kinds carried on the tuser side channel.
  localparam logic OP_ABSORB = 1'b0;
  localparam logic OP_FINISH = 1'b1;

  localparam logic [7:0] PAD_MARK = 8'h80;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PRE0,
    ST_PRE1,
    ST_ROUND,
    ST_UPDATE,
    ST_FILL,
    ST_OUT
  } state_t;

  function automatic logic [31:0] init_hash(input logic [2:0] idx);
    logic [31:0] v;
    case (idx)
      3'd0:    v = 32'h6a09e667;
      3'd1:    v = 32'hbb67ae85;
      3'd2:    v = 32'h3c6ef372;
      3'd3:    v = 32'ha54ff53a;
      3'd4:    v = 32'h510e527f;
      3'd5:    v = 32'h9b05688c;
      3'd6:    v = 32'h1f83d9ab;
      default: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] r);
    logic [31:0] v;
    case (r)
      6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
      6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
      6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
      6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
      6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
      6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
      6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
      6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
      6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
      6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
      6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
      6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
      6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
      6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
      6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
      6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
      6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
      6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
      6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
      6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
      6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
      6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
      6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
      6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
      6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
      6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
      6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
      6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
      6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
      6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
      6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
      6'd62: v = 32'hbef9a3f7;  default: v = 32'hc67178f2;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

// ===== hdl/sha256_stream_hasher_unit.sv =====
// A data byte is accepted whenever the unit is idle. The 64th byte of a block stalls input while
// the block is compressed: prefetch states PRE0 and PRE1, 64 rounds at one round per cycle, one hash update.
// A finish word writes the padding one schedule word per cycle, runs one or
// two compressions, then presents the eight digest words, one per cycle while out_tready is high.
// Absorb throughput is limited by the single round unit, since input stalls while each block is compressed.
// Synchronous active-low reset restores the initial hash and a zero count, not the schedule memory.
`default_nettype none

module sha256_stream_hasher_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic [0:0]  in_tuser,   // [0] operation
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] digest_word
  output logic [2:0]  out_tuser,  // [2:0] word_index
  output logic        out_tlast   // last_word
);
  import s256sh_pkg::*;

  state_t      state_r, state_nxt;
  logic [60:0] cnt_r;
  logic [23:0] acc_r;
  logic [31:0] hash_r [8];
  logic [31:0] wk_r [8];
  logic [5:0]  rnd_r;
  logic [31:0] w16_r, wm1_r, wm2_r;
  logic [3:0]  fill_idx_r, wi_r;
  logic [31:0] pad_r;
  logic        fin_r, two_r, pass_r;
  logic [2:0]  oidx_r;

  logic [31:0] sched_mem [16];
  logic [31:0] rda_r, rdb_r;
  logic [3:0]  rda_addr, rdb_addr, wr_addr;
  logic [31:0] wr_data;
  logic        wr_en;

  logic [5:0]  pos;
  logic        in_acc, absorb, finish, out_acc, last_out;
  logic [31:0] w_cur, t1, t2, fill_data, pad_word;
  logic [63:0] bit_len;

  assign pos      = cnt_r[5:0];
  assign in_acc   = in_tvalid & in_tready;
  assign absorb   = in_acc & (in_tuser[0] == OP_ABSORB);
  assign finish   = in_acc & (in_tuser[0] == OP_FINISH);
  assign out_acc  = out_tvalid & out_tready;
  assign last_out = out_acc & (oidx_r == 3'd7);
  assign bit_len  = {cnt_r, 3'b000};

  // Schedule word for this round; the first 16 come straight from the block.
  always_comb begin
    if (rnd_r[5:4] == 2'b00) begin
      w_cur = w16_r;
    end else begin
      w_cur = w16_r + small_sig0(rda_r) + rdb_r + small_sig1(wm2_r);
    end
    t1 = wk_r[7] + big_sig1(wk_r[4]) + ((wk_r[4] & wk_r[5]) ^ (~wk_r[4] & wk_r[6]))
       + round_k(rnd_r) + w_cur;
    t2 = big_sig0(wk_r[0]) + ((wk_r[0] & wk_r[1]) ^ (wk_r[0] & wk_r[2]) ^ (wk_r[1] & wk_r[2]));
  end

  always_comb begin
    case (pos[1:0])
      2'd0:    pad_word = {PAD_MARK, 24'h0};
      2'd1:    pad_word = {acc_r[7:0], PAD_MARK, 16'h0};
      2'd2:    pad_word = {acc_r[15:0], PAD_MARK, 8'h0};
      default: pad_word = {acc_r[23:0], PAD_MARK};
    endcase
  end

  // The length goes only into the final block of the message.
  always_comb begin
    fill_data = '0;
    if (!pass_r && fill_idx_r == wi_r) begin
      fill_data = pad_r;
    end else if (pass_r || !two_r) begin
      if (fill_idx_r == 4'd14) begin
        fill_data = bit_len[63:32];
      end else if (fill_idx_r == 4'd15) begin
        fill_data = bit_len[31:0];
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (finish) begin
          state_nxt = ST_FILL;
        end else if (absorb && pos == 6'd63) begin
          state_nxt = ST_PRE0;
        end
      end
      ST_PRE0:  state_nxt = ST_PRE1;
      ST_PRE1:  state_nxt = ST_ROUND;
      ST_ROUND: begin
        if (rnd_r == 6'd63) begin
          state_nxt = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        if (!fin_r) begin
          state_nxt = ST_IDLE;
        end else if (two_r && !pass_r) begin
          state_nxt = ST_FILL;
        end else begin
          state_nxt = ST_OUT;
        end
      end
      ST_FILL: begin
        if (fill_idx_r == 4'd15) begin
          state_nxt = ST_PRE0;
        end
      end
      ST_OUT: begin
        if (last_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    out_tvalid = 1'b0;
    rda_addr   = '0;
    rdb_addr   = '0;
    wr_en      = 1'b0;
    wr_addr    = pos[5:2];
    wr_data    = {acc_r, in_tdata};
    unique case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        wr_en     = absorb && (pos[1:0] == 2'd3);
      end
      ST_PRE0: rda_addr = 4'd0;
      ST_PRE1: begin
        rda_addr = 4'd1;
        rdb_addr = 4'd9;
      end
      ST_ROUND: begin
        // Reads are issued ahead of the round that uses them: w[r-15] feeds the next round's w[r-16] as well.
        rda_addr = rnd_r[3:0] + 4'd2;
        rdb_addr = rnd_r[3:0] + 4'd10;
        wr_en    = 1'b1;
        wr_addr  = rnd_r[3:0];
        wr_data  = w_cur;
      end
      ST_UPDATE: ;
      ST_FILL: begin
        wr_en   = 1'b1;
        wr_addr = fill_idx_r;
        wr_data = fill_data;
      end
      ST_OUT: out_tvalid = 1'b1;
      default: ;
    endcase
  end

  assign out_tdata = hash_r[oidx_r];
  assign out_tuser = oidx_r;
  assign out_tlast = (oidx_r == 3'd7);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      sched_mem[wr_addr] <= wr_data;
    end
    rda_r <= sched_mem[rda_addr];
    rdb_r <= sched_mem[rdb_addr];
  end

  always_ff @(posedge clk) begin
    if (absorb) begin
      acc_r <= {acc_r[15:0], in_tdata};
    end
    if (finish) begin
      wi_r  <= pos[5:2];
      pad_r <= pad_word;
      two_r <= (pos[5:3] == 3'b111);
    end
    if (finish) begin
      fill_idx_r <= pos[5:2];
    end else if (state_r == ST_UPDATE) begin
      fill_idx_r <= '0;
    end else if (state_r == ST_FILL) begin
      fill_idx_r <= fill_idx_r + 4'd1;
    end
    if (state_r == ST_PRE0) begin
      for (int j = 0; j < 8; j++) begin
        wk_r[j] <= hash_r[j];
      end
    end
    if (state_r == ST_PRE1) begin
      w16_r <= rda_r;
    end
    if (state_r == ST_ROUND) begin
      w16_r <= rda_r;
      wm1_r <= w_cur;
      wm2_r <= wm1_r;
      wk_r[0] <= t1 + t2;
      wk_r[1] <= wk_r[0];
      wk_r[2] <= wk_r[1];
      wk_r[3] <= wk_r[2];
      wk_r[4] <= wk_r[3] + t1;
      wk_r[5] <= wk_r[4];
      wk_r[6] <= wk_r[5];
      wk_r[7] <= wk_r[6];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      rnd_r   <= '0;
      fin_r   <= 1'b0;
      pass_r  <= 1'b0;
      oidx_r  <= '0;
      for (int j = 0; j < 8; j++) begin
        hash_r[j] <= init_hash(3'(j));
      end
    end else begin
      state_r <= state_nxt;
      if (absorb) begin
        cnt_r <= cnt_r + 61'd1;
      end
      if (finish) begin
        fin_r <= 1'b1;
      end
      if (state_r == ST_PRE1) begin
        rnd_r <= '0;
      end else if (state_r == ST_ROUND) begin
        rnd_r <= rnd_r + 6'd1;
      end
      if (state_r == ST_UPDATE) begin
        for (int j = 0; j < 8; j++) begin
          hash_r[j] <= hash_r[j] + wk_r[j];
        end
        if (fin_r && two_r && !pass_r) begin
          pass_r <= 1'b1;
        end
      end
      if (out_acc) begin
        oidx_r <= oidx_r + 3'd1;
      end
      if (last_out) begin
        cnt_r  <= '0;
        fin_r  <= 1'b0;
        pass_r <= 1'b0;
        for (int j = 0; j < 8; j++) begin
          hash_r[j] <= init_hash(3'(j));
        end
      end
    end
  end

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready)
    else $error("input accepted while digest words are pending");

  a_round_end: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND && rnd_r == 6'd63) |=> (state_r == ST_UPDATE))
    else $error("compression did not end after 64 rounds");

  a_sched_hazard: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ROUND) |-> (wr_addr != rda_addr && wr_addr != rdb_addr))
    else $error("schedule write collides with a read");

  a_block_start: assert property (@(posedge clk) disable iff (!rst_n)
    (absorb && pos == 6'd63) |=> (state_r == ST_PRE0))
    else $error("full block did not start a compression");

  a_digest_done: assert property (@(posedge clk) disable iff (!rst_n)
    last_out |=> (cnt_r == '0 && in_tready && !fin_r))
    else $error("state not restored after the digest");

endmodule

`default_nettype wire

// ===== tb/tb_sha256_stream_hasher_unit.sv =====
`timescale 1ns / 1ps

module tb_sha256_stream_hasher_unit;
  import s256sh_pkg::*;

  localparam int N_ITEMS = 450;
  localparam int IDLE_LIMIT = 5000;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
    logic       drain;   // hold this word until every digest word is back
    logic       burst;   // no gap after this word
  } msg_word_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic [0:0]  in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  msg_word_t    stream_q[$];
  digest_word_t digest_q[$];

  logic [31:0] hash_st [0:7];
  logic [7:0]  blk_buf [0:63];
  logic [60:0] n_bytes;

  logic [31:0] sha_iv [0:7] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  logic [31:0] sha_k [0:63] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  int errors = 0;
  int n_items = 0;
  int n_msgs = 0;
  int n_words = 0;
  int tx_gap = 0;
  int rx_stall = 0;
  int rx_quiet = 0;
  int idle_cycles = 0;

  sha256_stream_hasher_unit DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  // Mostly short gaps, now and then a long one.
  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void hash_reset();
    for (int j = 0; j < 8; j++) hash_st[j] = sha_iv[j];
    n_bytes = '0;
  endfunction

  function automatic void sha_compress();
    logic [31:0] w [0:15];
    logic [31:0] a, b, c, d, e, f, g, h;
    logic [31:0] wr, x15, x2, t1, t2;
    for (int j = 0; j < 16; j++)
      w[j] = {blk_buf[4*j], blk_buf[4*j+1], blk_buf[4*j+2], blk_buf[4*j+3]};
    a = hash_st[0]; b = hash_st[1]; c = hash_st[2]; d = hash_st[3];
    e = hash_st[4]; f = hash_st[5]; g = hash_st[6]; h = hash_st[7];
    for (int r = 0; r < 64; r++) begin
      if (r < 16) begin
        wr = w[r];
      end else begin
        // The schedule rolls through sixteen words in place.
        x15 = w[(r - 15) & 15];
        x2 = w[(r - 2) & 15];
        wr = w[r & 15] + (ror32(x15, 7) ^ ror32(x15, 18) ^ (x15 >> 3)) +
             w[(r - 7) & 15] + (ror32(x2, 17) ^ ror32(x2, 19) ^ (x2 >> 10));
        w[r & 15] = wr;
      end
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g)) +
           sha_k[r] + wr;
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_st[0] += a; hash_st[1] += b; hash_st[2] += c; hash_st[3] += d;
    hash_st[4] += e; hash_st[5] += f; hash_st[6] += g; hash_st[7] += h;
  endfunction

  // Applies one accepted word to the predicted hash state and queues the digest on a finish.
  function automatic void hash_accept(input logic op, input logic [7:0] data);
    int pos;
    logic [63:0] bit_len;
    digest_word_t dw;
    pos = int'(n_bytes[5:0]);
    if (op == OP_ABSORB) begin
      blk_buf[pos] = data;
      n_bytes = n_bytes + 61'd1;
      if (pos == 63) sha_compress();
    end else begin
      bit_len = {n_bytes, 3'b000};
      blk_buf[pos] = 8'h80;
      pos++;
      // No room for the length field: pad out this block and start another.
      if (pos > 56) begin
        while (pos < 64) begin
          blk_buf[pos] = 8'h00;
          pos++;
        end
        sha_compress();
        pos = 0;
      end
      while (pos < 56) begin
        blk_buf[pos] = 8'h00;
        pos++;
      end
      for (int j = 0; j < 8; j++) blk_buf[56 + j] = bit_len[63 - 8*j -: 8];
      sha_compress();
      for (int j = 0; j < 8; j++) begin
        dw.word = hash_st[j];
        dw.idx = 3'(j);
        dw.last = (j == 7);
        digest_q.push_back(dw);
      end
      hash_reset();
      n_msgs++;
    end
  endfunction

  function automatic void queue_word(input logic op, input logic [7:0] data,
                                     input logic drain, input logic burst);
    msg_word_t m;
    m.op = op;
    m.data = data;
    m.drain = drain;
    m.burst = burst;
    stream_q.push_back(m);
  endfunction

  function automatic void queue_message(input int len, input logic drain);
    logic burst;
    logic [7:0] d;
    int r;
    burst = ($urandom_range(0, 3) == 0);
    for (int j = 0; j < len; j++) begin
      r = $urandom_range(0, 9);
      d = (r == 0) ? 8'h00 : (r == 1) ? 8'hff : 8'($urandom_range(0, 255));
      queue_word(OP_ABSORB, d, drain && (j == 0), burst);
    end
    // The byte that travels with a finish is ignored, so it is random.
    queue_word(OP_FINISH, 8'($urandom_range(0, 255)), drain && (len == 0), burst);
  endfunction

  always @(posedge clk) begin
    msg_word_t nxt;
    logic send;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      tx_gap = 0;
      hash_reset();
    end else begin
      if (in_tvalid && in_tready) begin
        hash_accept(in_tuser[0], in_tdata);
        n_items++;
      end
      if (!in_tvalid || in_tready) begin
        send = 1'b0;
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (stream_q.size() > 0 &&
                     !(stream_q[0].drain && digest_q.size() > 0)) begin
          nxt = stream_q.pop_front();
          in_tdata <= nxt.data;
          in_tuser <= nxt.op;
          send = 1'b1;
          tx_gap = nxt.burst ? 0 : gap_len();
        end
        in_tvalid <= send;
      end
    end
  end

  always @(posedge clk) begin
    digest_word_t exp_w;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_stall = 0;
      rx_quiet = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (digest_q.size() == 0) begin
          $error("digest word %h with none expected", out_tdata);
          errors++;
        end else begin
          exp_w = digest_q.pop_front();
          n_words++;
          if (out_tdata !== exp_w.word) begin
            $error("digest_word: expected %h, got %h", exp_w.word, out_tdata);
            errors++;
          end
          if (out_tuser !== exp_w.idx) begin
            $error("word_index: expected %0d, got %0d", exp_w.idx, out_tuser);
            errors++;
          end
          if (out_tlast !== exp_w.last) begin
            $error("last_word: expected %b, got %b", exp_w.last, out_tlast);
            errors++;
          end
        end
      end
      if (rx_quiet > 0) begin
        rx_quiet--;
        out_tready <= 1'b1;
      end else if (rx_stall > 0) begin
        rx_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        rx_stall = gap_len();
        if ($urandom_range(0, 63) == 0) rx_quiet = $urandom_range(20, 80);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("no word moved for %0d cycles", IDLE_LIMIT);
        $display("CHECK FAILED");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int total;
    int msg_no;
    int len;
    int boundary_len [0:12];

    boundary_len = '{1, 54, 55, 56, 57, 62, 63, 64, 65, 119, 120, 127, 128};

    // Empty message twice in a row (ignored byte 00, ff), then 2-, 3- and 1-byte messages.
    queue_word(OP_FINISH, 8'h00, 1'b0, 1'b0);
    queue_word(OP_FINISH, 8'hff, 1'b0, 1'b0);
    queue_word(OP_ABSORB, 8'h00, 1'b0, 1'b0);
    queue_word(OP_ABSORB, 8'hff, 1'b0, 1'b0);
    queue_word(OP_FINISH, 8'h00, 1'b0, 1'b0);
    queue_word(OP_ABSORB, 8'h61, 1'b1, 1'b1);
    queue_word(OP_ABSORB, 8'h62, 1'b0, 1'b1);
    queue_word(OP_ABSORB, 8'h63, 1'b0, 1'b1);
    queue_word(OP_FINISH, 8'h55, 1'b0, 1'b0);
    queue_word(OP_ABSORB, 8'haa, 1'b0, 1'b0);
    queue_word(OP_FINISH, 8'haa, 1'b0, 1'b0);

    // Random messages; lengths near the padding and block edges come up often.
    total = stream_q.size();
    msg_no = 0;
    while (total < N_ITEMS) begin
      if ($urandom_range(0, 9) < 4) len = boundary_len[$urandom_range(0, 12)];
      else len = $urandom_range(0, 40);
      // The last message is cut short so the word count lands on the target.
      if (len > N_ITEMS - total - 1) len = N_ITEMS - total - 1;
      queue_message(len, (msg_no % 4) == 1);
      total += len + 1;
      msg_no++;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    while (stream_q.size() != 0 || in_tvalid) @(posedge clk);
    while (digest_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Hashed %0d messages from %0d input words, checked %0d digest words.",
             n_msgs, n_items, n_words);
    $display("Lengths spanned empty, one-block and two-block padding, with random stalls.");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/s256sh_pkg.sv
hdl/sha256_stream_hasher_unit.sv
tb/tb_sha256_stream_hasher_unit.sv
